/* rtl/blist_pkg.sv */
package blist_pkg;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_FIND       = 3'd4;
  localparam logic [2:0] MODE_ERASE      = 3'd5;
  localparam logic [2:0] MODE_QUERY      = 3'd6;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUT,
    ST_RD_FRONT,
    ST_RD_BACK,
    ST_CAP_BACK,
    ST_DONE
  } state_t;

  // One finished result.
  typedef struct packed {
    status_t            status;
    logic               found;
    logic signed [31:0] front_key;
    logic signed [31:0] back_key;
    logic [4:0]         entry_count;
  } result_t;

endpackage

/* rtl/blist_in_if.sv */
interface blist_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] key_value;
  logic [3:0]         position;

  modport source (output valid, mode, key_value, position, input ready);
  modport sink (input valid, mode, key_value, position, output ready);
endinterface

/* rtl/blist_out_if.sv */
interface blist_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic signed [31:0] front_key;
  logic signed [31:0] back_key;
  logic [4:0]         entry_count;

  modport source (output valid, status, found, front_key, back_key, entry_count,
                  input ready);
  modport sink (input valid, status, found, front_key, back_key, entry_count,
                output ready);
endinterface

/* rtl/blist_core.sv */
module blist_core #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  blist_in_if.sink          request,
  output logic              done_valid,
  input  logic              done_ready,
  output blist_pkg::result_t done_data
);
  import blist_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Key storage, front of the list at address zero.
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic signed [31:0] wdata;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               we;

  state_t state, state_next;

  logic [2:0]         mode_q;
  logic signed [31:0] key_q;
  status_t            status_q;
  logic               found;
  logic signed [31:0] front_key;
  logic signed [31:0] back_key;
  logic [CW-1:0]      count;
  logic [CW-1:0]      left;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      dst;
  logic [AW-1:0]      put_idx;
  logic               asc;
  logic               pend;
  logic               front_put;

  logic               accept;
  logic               full;
  logic               empty;
  logic               is_find;

  // Plan for the accepted operation.
  state_t             plan_state;
  status_t            plan_status;
  logic [CW-1:0]      plan_left;
  logic [AW-1:0]      plan_idx;
  logic               plan_asc;
  logic [CW-1:0]      plan_count;
  logic               plan_put;
  logic [AW-1:0]      plan_put_idx;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign full          = (count == CW'(DEPTH));
  assign empty         = (count == '0);
  assign is_find       = (mode_q == MODE_FIND);

  // Decode the incoming operation into a shift or scan plan.
  always_comb begin
    plan_state   = ST_RD_FRONT;
    plan_status  = STATUS_OK;
    plan_left    = '0;
    plan_idx     = '0;
    plan_asc     = 1'b1;
    plan_count   = count;
    plan_put     = 1'b0;
    plan_put_idx = '0;
    unique case (request.mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          plan_status = STATUS_FULL;
        end else begin
          plan_state = ST_RUN;
          plan_left  = count;
          plan_idx   = AW'(count - CW'(1));
          plan_asc   = 1'b0;
          plan_put   = 1'b1;
          plan_count = count + CW'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          plan_status = STATUS_FULL;
        end else begin
          plan_state   = ST_PUT;
          plan_put_idx = AW'(count);
          plan_count   = count + CW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          plan_status = STATUS_EMPTY;
        end else begin
          plan_state = ST_RUN;
          plan_left  = count - CW'(1);
          plan_idx   = AW'(1);
          plan_count = count - CW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          plan_status = STATUS_EMPTY;
        end else begin
          plan_count = count - CW'(1);
        end
      end
      MODE_FIND: begin
        plan_state = ST_RUN;
        plan_left  = count;
      end
      MODE_ERASE: begin
        if (empty) begin
          plan_status = STATUS_EMPTY;
        end else if (int'(request.position) >= int'(count)) begin
          plan_status = STATUS_RANGE;
        end else begin
          plan_state = ST_RUN;
          plan_left  = CW'(int'(count) - int'(request.position) - 1);
          plan_idx   = AW'(int'(request.position) + 1);
          plan_count = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    raddr      = rd_idx;
    we         = 1'b0;
    waddr      = dst;
    wdata      = rd_data;
    done_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = plan_state;
        end
      end
      ST_RUN: begin
        we = pend && !is_find;
        if (left == '0 && !pend) begin
          state_next = front_put ? ST_PUT : ST_RD_FRONT;
        end
      end
      ST_PUT: begin
        we         = 1'b1;
        waddr      = put_idx;
        wdata      = key_q;
        state_next = ST_RD_FRONT;
      end
      ST_RD_FRONT: begin
        raddr      = '0;
        state_next = ST_RD_BACK;
      end
      ST_RD_BACK: begin
        raddr      = AW'(count - CW'(1));
        state_next = ST_CAP_BACK;
      end
      ST_CAP_BACK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // Datapath registers: one element moved or compared per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      left  <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_q    <= request.mode;
            key_q     <= request.key_value;
            status_q  <= plan_status;
            found     <= 1'b0;
            count     <= plan_count;
            left      <= plan_left;
            rd_idx    <= plan_idx;
            asc       <= plan_asc;
            front_put <= plan_put;
            put_idx   <= plan_put_idx;
            pend      <= 1'b0;
          end
        end
        ST_RUN: begin
          if (left != '0) begin
            rd_idx <= asc ? rd_idx + AW'(1) : rd_idx - AW'(1);
            left   <= left - CW'(1);
          end
          pend <= (left != '0);
          dst  <= asc ? rd_idx - AW'(1) : rd_idx + AW'(1);
          if (pend && is_find && rd_data == key_q) begin
            found <= 1'b1;
          end
        end
        ST_RD_BACK: begin
          front_key <= rd_data;
        end
        ST_CAP_BACK: begin
          back_key <= rd_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Result assembly; an empty list reports zero keys.
  always_comb begin
    done_data.status      = status_q;
    done_data.found       = found;
    done_data.front_key   = empty ? 32'sd0 : front_key;
    done_data.back_key    = empty ? 32'sd0 : back_key;
    done_data.entry_count = 5'(count);
  end

  // The count never runs past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds capacity");

  // A push onto a list with room grows it by exactly one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !full &&
     (request.mode == MODE_PUSH_FRONT || request.mode == MODE_PUSH_BACK))
    |=> count == $past(count) + CW'(1))
    else $error("push did not grow the list by one");

  // Removing from an empty list reports empty and keeps it empty.
  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (request.mode == MODE_POP_FRONT ||
     request.mode == MODE_POP_BACK || request.mode == MODE_ERASE))
    |=> count == '0 && status_q == STATUS_EMPTY)
    else $error("remove on empty list changed state or status");

  // Only a find can report a match.
  a_found_find: assert property (@(posedge clk) disable iff (rst)
    (done_valid && done_data.found) |-> is_find)
    else $error("found flag set outside find");

endmodule

/* rtl/blist_outreg.sv */
module blist_outreg (
  input  logic               clk,
  input  logic               rst,
  input  logic               done_valid,
  output logic               done_ready,
  input  blist_pkg::result_t done_data,
  blist_out_if.source        result
);
  import blist_pkg::*;

  logic    valid;
  result_t data;

  // The slot takes a new result when empty or when its content leaves now.
  assign done_ready = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (done_ready) begin
      valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      data <= done_data;
    end
  end

  assign result.valid       = valid;
  assign result.status      = data.status;
  assign result.found       = data.found;
  assign result.front_key   = data.front_key;
  assign result.back_key    = data.back_key;
  assign result.entry_count = data.entry_count;

endmodule

/* rtl/bounded_ordered_list.sv */
// Channel   Role   Transfer contents
// request   sink   mode, key_value, position
// result    source status, found, front_key, back_key, entry_count
//
// The block takes no new request until the previous operation has finished and
// handed on its result. Find, push front, pop front and erase walk up to DEPTH
// stored keys through the memory, which moves or compares one stored key per
// cycle. Pops from the back, queries and rejected operations skip the walk;
// pushes to the back only write the new key.
// Reset (rst, synchronous) empties the list; stored keys are not cleared.
// A finished result waits in an output register, so a stalled result
// channel blocks only the next operation's completion, not its transfer.
module bounded_ordered_list #(
  parameter int DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  blist_in_if.sink    request,
  blist_out_if.source result
);
  import blist_pkg::*;

  logic    done_valid;
  logic    done_ready;
  result_t done_data;

  blist_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .done_valid(done_valid),
    .done_ready(done_ready),
    .done_data (done_data)
  );

  blist_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .done_valid(done_valid),
    .done_ready(done_ready),
    .done_data (done_data),
    .result    (result)
  );

endmodule

/* tb/bounded_ordered_list_test.sv */
`timescale 1ns / 1ps

module bounded_ordered_list_test;
  import blist_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int LATENCY_CYCLES = LIST_DEPTH + 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 550;

  // The mode field has one spare code, which acts as a query.
  localparam logic [2:0] MODE_SPARE = 3'd7;

  // Traffic shapes for the random part.
  localparam int TREND_GROW = 0;
  localparam int TREND_SHRINK = 1;
  localparam int TREND_MIXED = 2;

  logic clk;
  logic rst;

  blist_in_if request_if ();
  blist_out_if result_if ();

  bounded_ordered_list #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .request(request_if),
    .result(result_if)
  );

  // Predicted list contents and the snapshots still owed by the block.
  logic signed [31:0] list_keys [LIST_DEPTH];
  int list_len;
  result_t pending_snapshots [$];
  result_t oldest_snapshot;

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  // Free-running clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one operation to the predicted list and return the snapshot after it.
  function automatic result_t apply_list_op(logic [2:0] op, logic signed [31:0] key,
                                            logic [3:0] pos);
    result_t snap;
    snap.status = STATUS_OK;
    snap.found = 1'b0;
    snap.front_key = '0;
    snap.back_key = '0;
    case (op)
      MODE_PUSH_FRONT: begin
        if (list_len >= LIST_DEPTH) begin
          snap.status = STATUS_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_keys[i] = list_keys[i - 1];
          list_keys[0] = key;
          list_len++;
        end
      end
      MODE_PUSH_BACK: begin
        if (list_len >= LIST_DEPTH) begin
          snap.status = STATUS_FULL;
        end else begin
          list_keys[list_len] = key;
          list_len++;
        end
      end
      MODE_POP_FRONT: begin
        if (list_len == 0) begin
          snap.status = STATUS_EMPTY;
        end else begin
          for (int i = 0; i < list_len - 1; i++) list_keys[i] = list_keys[i + 1];
          list_len--;
        end
      end
      MODE_POP_BACK: begin
        if (list_len == 0) snap.status = STATUS_EMPTY;
        else list_len--;
      end
      MODE_FIND: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_keys[i] == key) snap.found = 1'b1;
        end
      end
      MODE_ERASE: begin
        if (list_len == 0) begin
          snap.status = STATUS_EMPTY;
        end else if (int'(pos) >= list_len) begin
          snap.status = STATUS_RANGE;
        end else begin
          for (int i = int'(pos); i < list_len - 1; i++) list_keys[i] = list_keys[i + 1];
          list_len--;
        end
      end
      default: begin
      end
    endcase
    if (list_len > 0) begin
      snap.front_key = list_keys[0];
      snap.back_key = list_keys[list_len - 1];
    end
    snap.entry_count = 5'(list_len);
    return snap;
  endfunction

  // Report one differing field of a result transfer.
  function automatic void compare_field(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  // Present one operation and wait for its transfer; the prediction is taken then.
  task automatic send_op(input logic [2:0] op, input logic signed [31:0] key,
                         input logic [3:0] pos);
    result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      request_if.valid = 1'b0;
      @(negedge clk);
    end
    request_if.valid = 1'b1;
    request_if.mode = op;
    request_if.key_value = key;
    request_if.position = pos;
    @(posedge clk);
    while (!request_if.ready) @(posedge clk);
    predicted = apply_list_op(op, key, pos);
    pending_snapshots.insert(pending_snapshots.size(), predicted);
  endtask

  // Hold off new operations until every outstanding result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    request_if.valid = 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
  endtask

  // Draw a key: often one already stored, sometimes an extreme, else anything.
  function automatic logic signed [31:0] choose_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30 && list_len > 0) return list_keys[$urandom_range(list_len - 1)];
    if (roll < 45) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return 32'shffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // Draw an erase position, mostly one that lies inside the list.
  function automatic logic [3:0] choose_position();
    if (list_len > 0 && $urandom_range(3) != 0) return 4'($urandom_range(list_len - 1));
    return 4'($urandom_range(15));
  endfunction

  // Draw an operation that leans toward growing or shrinking the list, or any mode for the mixed trend.
  function automatic logic [2:0] choose_op(int trend);
    int roll;
    logic [2:0] push_op;
    logic [2:0] pop_op;
    roll = $urandom_range(99);
    push_op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    pop_op = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
    if (trend == TREND_MIXED) return 3'($urandom_range(7));
    if (trend == TREND_GROW) begin
      if (roll < 60) return push_op;
      if (roll < 70) return MODE_FIND;
      if (roll < 80) return pop_op;
      if (roll < 90) return MODE_ERASE;
    end else begin
      if (roll < 20) return push_op;
      if (roll < 30) return MODE_FIND;
      if (roll < 60) return pop_op;
      if (roll < 90) return MODE_ERASE;
    end
    return $urandom_range(1) ? MODE_QUERY : MODE_SPARE;
  endfunction

  // Receiver side: ready changes on the falling edge.
  always @(negedge clk) begin
    result_if.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each result transfer against the oldest predicted snapshot.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_snapshots.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h %h %h %h %h", $time,
                 result_if.status, result_if.found, result_if.front_key,
                 result_if.back_key, result_if.entry_count);
        mismatch_count++;
      end else begin
        oldest_snapshot = pending_snapshots[0];
        pending_snapshots.delete(0);
        compare_field("status", 32'(oldest_snapshot.status), 32'(result_if.status));
        compare_field("found", 32'(oldest_snapshot.found), 32'(result_if.found));
        compare_field("front_key", oldest_snapshot.front_key, result_if.front_key);
        compare_field("back_key", oldest_snapshot.back_key, result_if.back_key);
        compare_field("entry_count", 32'(oldest_snapshot.entry_count),
                      32'(result_if.entry_count));
      end
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounded_ordered_list: mismatch");
      $finish;
    end
  end

  // Every removal and erase on an empty list, plus the spare mode.
  task automatic test_empty_list();
    send_op(MODE_POP_FRONT, 32'sd0, 4'd0);
    send_op(MODE_POP_BACK, 32'sd0, 4'd0);
    send_op(MODE_ERASE, 32'sd0, 4'd0);
    send_op(MODE_SPARE, 32'shffff_ffff, 4'd15);
  endtask

  // Push at the front of an empty list, search for it and for an absent key, then empty the list and query it.
  task automatic test_single_key();
    send_op(MODE_PUSH_FRONT, 32'sh8000_0000, 4'd0);
    send_op(MODE_FIND, 32'sh8000_0000, 4'd0);
    send_op(MODE_FIND, 32'sh7fff_ffff, 4'd0);
    send_op(MODE_POP_FRONT, 32'sd0, 4'd0);
    send_op(MODE_QUERY, 32'sd0, 4'd0);
  endtask

  // Fill the list, push onto a full list, then erase at and past the end.
  task automatic test_full_list();
    send_op(MODE_PUSH_BACK, 32'sh7fff_ffff, 4'd0);
    for (int i = 1; i < LIST_DEPTH; i++) begin
      send_op((i % 2) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, $urandom, 4'd0);
    end
    send_op(MODE_PUSH_FRONT, 32'sd1, 4'd0);
    send_op(MODE_PUSH_BACK, 32'sd2, 4'd0);
    send_op(MODE_ERASE, 32'sd0, 4'd15);
    send_op(MODE_ERASE, 32'sd0, 4'd15);
  endtask

  // Bursts that grow, shrink or stir the list, with random keys and positions.
  task automatic test_random_traffic(input int item_count);
    int burst_left;
    int trend;
    logic [2:0] op;
    burst_left = 0;
    trend = TREND_MIXED;
    for (int n = 0; n < item_count; n++) begin
      if (burst_left == 0) begin
        trend = $urandom_range(2);
        burst_left = $urandom_range(8, 40);
      end
      burst_left--;
      op = choose_op(trend);
      send_op(op, choose_key(), choose_position());
      if ($urandom_range(199) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // Reset, then the tests in turn.
  initial begin
    rst = 1'b1;
    mismatch_count = 0;
    cycle_count = 0;
    list_len = 0;
    send_idle_pct = 11;
    recv_idle_pct = 54;
    request_if.valid = 1'b0;
    request_if.mode = MODE_QUERY;
    request_if.key_value = '0;
    request_if.position = '0;
    result_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_single_key();
    test_full_list();
    test_random_traffic(ITEMS_PER_PHASE);

    send_idle_pct = 54;
    recv_idle_pct = 11;
    test_random_traffic(ITEMS_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(ITEMS_PER_PHASE);

    wait_for_results();
    repeat (LATENCY_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bounded_ordered_list: match");
    end else begin
      $display("bounded_ordered_list: mismatch");
    end
    $finish;
  end

endmodule
